// ----- src/double_ended_queue_assert.svh -----
// Assertion macros for the double-ended queue.
// Used by the datapath; needs nothing else.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, skipped during reset.
`define DEQ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped during reset.
`define DEQ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// No dependencies.
package deq_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   localparam logic [1:0] MODE_INS_FRONT = 2'd0;
   localparam logic [1:0] MODE_REM_FRONT = 2'd1;
   localparam logic [1:0] MODE_INS_BACK  = 2'd2;
   localparam logic [1:0] MODE_REM_BACK  = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic CSR_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_OUT
   } deq_state_type;

   typedef struct packed {
      logic capture;    // latch the accepted item
      logic execute;    // run the operation on the buffer
      logic take_read;  // move the read word to the result register
   } deq_cmd_type;

   typedef struct packed {
      logic remove_ok;  // current item is a removal that will succeed
   } deq_stat_type;

endpackage

// ----- src/deq_ctrl.sv -----
// Sequencer for the double-ended queue: one item at a time through
// capture, execute, optional read fetch and result hand-off. Uses deq_pkg.
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output deq_pkg::deq_cmd_type  cmd,
   input  deq_pkg::deq_stat_type stat
);
   import deq_pkg::*;

   deq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.remove_ok ? ST_FETCH : ST_OUT;
         end
         ST_FETCH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      cmd.take_read = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_FETCH: begin
            cmd.take_read = 1'b1;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- src/deq_datapath.sv -----
// Circular buffer, front index, occupancy and result registers of the
// double-ended queue. Uses deq_pkg and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module deq_datapath #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  deq_pkg::deq_cmd_type              cmd,
   output deq_pkg::deq_stat_type             stat,
   input  logic [1:0]                        mode,
   input  logic signed [deq_pkg::DATA_W-1:0] data_in,
   input  logic [deq_pkg::CAP_W-1:0]         capacity,
   output logic [1:0]                        status,
   output logic signed [deq_pkg::DATA_W-1:0] data_out
);
   import deq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(2 * DEPTH);
   localparam int EW = (OW > CAP_W) ? OW : CAP_W;

   logic [1:0]              mode_ff;
   logic [DATA_W-1:0]       word_ff;
   logic [IW-1:0]           front_ff, front_in;
   logic [OW-1:0]           occ_ff, occ_in;
   logic [1:0]              status_ff;
   logic [DATA_W-1:0]       out_data_ff;
   logic [DATA_W-1:0]       rd_data_ff;
   logic [DATA_W-1:0]       mem [DEPTH];

   logic                    is_insert, at_front, full, empty;
   logic [SW-1:0]           sum_back, sum_last;
   logic [IW-1:0]           front_dec, front_inc, back_ins, back_last;
   logic [IW-1:0]           addr;
   logic                    mem_we, mem_re;

   function automatic logic [IW-1:0] wrap_pos(input logic [SW-1:0] pos);
      logic [SW-1:0] w;
      w = (pos >= SW'(DEPTH)) ? pos - SW'(DEPTH) : pos;
      return w[IW-1:0];
   endfunction

   assign is_insert = (mode_ff == MODE_INS_FRONT) || (mode_ff == MODE_INS_BACK);
   assign at_front  = (mode_ff == MODE_INS_FRONT) || (mode_ff == MODE_REM_FRONT);
   // capacity above DEPTH saturates: a full buffer refuses regardless
   assign full      = (occ_ff == OW'(DEPTH)) || (EW'(occ_ff) >= EW'(capacity));
   assign empty     = (occ_ff == '0);

   assign sum_back  = SW'(front_ff) + SW'(occ_ff);
   assign sum_last  = sum_back - SW'(1);
   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + IW'(1);
   assign back_ins  = wrap_pos(sum_back);
   assign back_last = wrap_pos(sum_last);

   assign stat.remove_ok = !is_insert && !empty;

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      addr     = front_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      if (cmd.execute) begin
         if (is_insert && !full) begin
            mem_we = 1'b1;
            occ_in = occ_ff + OW'(1);
            if (at_front) begin
               addr     = front_dec;
               front_in = front_dec;
            end else begin
               addr = back_ins;
            end
         end else if (!is_insert && !empty) begin
            mem_re = 1'b1;
            occ_in = occ_ff - OW'(1);
            if (at_front) begin
               addr     = front_ff;
               front_in = front_inc;
            end else begin
               addr = back_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= word_ff;
      if (mem_re) rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode;
         word_ff <= data_in;
      end
      if (cmd.execute) begin
         out_data_ff <= '0;
         if (is_insert) begin
            status_ff <= full ? STAT_FULL : STAT_OK;
         end else begin
            status_ff <= empty ? STAT_EMPTY : STAT_OK;
         end
      end else if (cmd.take_read) begin
         out_data_ff <= rd_data_ff;
      end
   end

   assign status   = status_ff;
   assign data_out = out_data_ff;

   `DEQ_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OW'(DEPTH),
      "occupancy above depth")
   `DEQ_ASSERT_NXT(a_refused_hold, clock, reset,
      cmd.execute && is_insert && full, $stable(occ_ff) && $stable(front_ff),
      "refused insert changed the queue")
   `DEQ_ASSERT_NXT(a_remove_dec, clock, reset, cmd.execute && stat.remove_ok,
      occ_ff == $past(occ_ff) - OW'(1), "removal did not drop occupancy")
   `DEQ_ASSERT_IMP(a_one_port_op, clock, reset, 1'b1, !(mem_we && mem_re),
      "buffer read and write in one cycle")

endmodule

// ----- src/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit words in a DEPTH-entry circular buffer.
// Once an item is accepted, the controller steps through EXEC and then OUT,
// where the result is valid; a successful removal passes FETCH in between
// (registered buffer read). A new item is taken only after the result has
// been handed off with rsp_tready high, in the capture/execute/fetch/hand-off order.
// Reset (synchronous): queue empty, front index zero, capacity 32.
module double_ended_queue #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic signed [deq_pkg::DATA_W-1:0] req_tdata,  // [31:0] data_in
   input  logic [1:0]                        req_tuser,  // [1:0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_tdata,  // [31:0] data_out
   output logic [1:0]                        rsp_tuser,  // [1:0] status
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import deq_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic             csr_wr;
   deq_cmd_type      cmd;
   deq_stat_type     stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_CAPACITY)) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_ff} : '0;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .mode     (req_tuser),
      .data_in  (req_tdata),
      .capacity (cap_ff),
      .status   (rsp_tuser),
      .data_out (rsp_tdata)
   );

endmodule
